[design/like_wildcard_matcher_defines.svh]
// Assertion macros shared by the checker of the wildcard matcher.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef LIKE_WILDCARD_MATCHER_DEFINES_SVH
`define LIKE_WILDCARD_MATCHER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define LWM_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("like_wildcard_matcher: check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define LWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("like_wildcard_matcher: check failed");

`endif

[design/lwm_pkg.sv]
package lwm_pkg;

  // Largest pattern the matcher can hold.
  localparam int PatternMax = 16;

  // Configuration port geometry.
  localparam int CfgWidth      = 64;
  localparam int CfgIndexWidth = 2;
  localparam int LenWidth      = 5;

  // Register indexes.
  localparam logic [CfgIndexWidth-1:0] CfgLow  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgHigh = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CfgLen  = 2'd2;

  // Input action codes.
  localparam logic [1:0] ActByte = 2'd0;
  localparam logic [1:0] ActLast = 2'd1;
  localparam logic [1:0] ActEnd  = 2'd2;

  // Special pattern characters.
  localparam logic [7:0] ChPercent    = 8'h25;
  localparam logic [7:0] ChUnderscore = 8'h5F;
  localparam logic [7:0] ChNul        = 8'h00;

  // Entries in the queue between front and back.
  localparam int QueueDepth = 2;

  // One classified item on its way to the back end.
  typedef struct packed {
    logic       step;    // item carries a text byte
    logic       finish;  // item ends the text
    logic [7:0] ch;      // case-folded text byte
  } lwm_op_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } lwm_qstat_t;

  // ASCII case folding, upper case to lower case.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

[design/lwm_cfg.sv]
module lwm_cfg #(
  parameter int PatternMax = lwm_pkg::PatternMax,
  localparam int VecW = PatternMax + 1,
  localparam int LenW = $clog2(PatternMax + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lwm_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [lwm_pkg::CfgWidth-1:0]       cfg_data_i,
  output logic [LenW-1:0]                    len_o,
  output logic [PatternMax-1:0]              in_use_o,
  output logic [PatternMax-1:0]              pct_o,
  output logic [PatternMax-1:0]              any_o,
  output logic [PatternMax-1:0][7:0]         pat_char_o,
  output logic [PatternMax-1:0][VecW-1:0]    span_o,
  output logic [VecW-1:0]                    start_o
);
  import lwm_pkg::*;

  logic [CfgWidth-1:0]             low_q, low_d;
  logic [CfgWidth-1:0]             high_q, high_d;
  logic [LenWidth-1:0]             len_raw_q, len_raw_d;
  logic [15:0][7:0]                raw_b;
  logic [LenW-1:0]                 len_sat;
  logic [LenW-1:0]                 len_q, len_d;
  logic [PatternMax-1:0]           in_use_q, in_use_d;
  logic [PatternMax-1:0]           pct_q, pct_d;
  logic [PatternMax-1:0]           any_q, any_d;
  logic [PatternMax-1:0][7:0]      pat_char_q, pat_char_d;
  logic [PatternMax-1:0][VecW-1:0] span_q, span_d;
  logic [VecW-1:0]                 start_q, start_d;

  // Register writes; index three is not a register and is dropped.
  always_comb begin
    low_d     = low_q;
    high_d    = high_q;
    len_raw_d = len_raw_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgLow:  low_d     = cfg_data_i;
        CfgHigh: high_d    = cfg_data_i;
        CfgLen:  len_raw_d = cfg_data_i[LenWidth-1:0];
        default: ;
      endcase
    end
  end

  // Decode the pattern from the next register values, so the decoded
  // form is ready in the same cycle as the registers themselves.
  always_comb begin
    logic run;
    raw_b = {high_d, low_d};
    if (len_raw_d > LenWidth'(PatternMax)) begin
      len_sat = LenW'(PatternMax);
    end else begin
      len_sat = LenW'(len_raw_d);
    end
    // A zero byte inside the used length cuts the pattern short.
    len_d = len_sat;
    for (int i = PatternMax - 1; i >= 0; i--) begin
      if (LenW'(i) < len_sat && raw_b[i] == ChNul) begin
        len_d = LenW'(i);
      end
    end
    for (int i = 0; i < PatternMax; i++) begin
      in_use_d[i]   = LenW'(i) < len_d;
      pct_d[i]      = in_use_d[i] && (raw_b[i] == ChPercent);
      any_d[i]      = in_use_d[i] && (raw_b[i] == ChUnderscore);
      pat_char_d[i] = fold_case(raw_b[i]);
    end
    // span[j][k]: positions j up to k-1 are all percent signs, so an
    // active position j also makes position k active.
    for (int j = 0; j < PatternMax; j++) begin
      for (int k = 0; k < VecW; k++) begin
        run = 1'b1;
        for (int m = 0; m < PatternMax; m++) begin
          if (m >= j && m < k) begin
            run = run & pct_d[m];
          end
        end
        span_d[j][k] = (k > j) && run;
      end
    end
    start_d = span_d[0] | VecW'(1);
  end

  // Control and decoded pattern state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q     <= '0;
      high_q    <= '0;
      len_raw_q <= '0;
      len_q     <= '0;
      in_use_q  <= '0;
      pct_q     <= '0;
      any_q     <= '0;
      span_q    <= '0;
      start_q   <= VecW'(1);
    end else begin
      low_q     <= low_d;
      high_q    <= high_d;
      len_raw_q <= len_raw_d;
      len_q     <= len_d;
      in_use_q  <= in_use_d;
      pct_q     <= pct_d;
      any_q     <= any_d;
      span_q    <= span_d;
      start_q   <= start_d;
    end
  end

  // Folded characters are only compared where a position is in use.
  always_ff @(posedge clk_i) begin
    pat_char_q <= pat_char_d;
  end

  assign len_o      = len_q;
  assign in_use_o   = in_use_q;
  assign pct_o      = pct_q;
  assign any_o      = any_q;
  assign pat_char_o = pat_char_q;
  assign span_o     = span_q;
  assign start_o    = start_q;

endmodule

[design/lwm_front.sv]
module lwm_front (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          action_i,
  input  logic [7:0]          text_byte_i,
  input  lwm_pkg::lwm_qstat_t qstat_i,
  output logic                push_o,
  output lwm_pkg::lwm_op_t    op_o
);
  import lwm_pkg::*;

  logic known;

  // The front end stalls only while the queue is full.
  assign in_stall_o = qstat_i.full;

  // Classify the action; the unused code is taken and dropped.
  always_comb begin
    known       = 1'b1;
    op_o.step   = 1'b0;
    op_o.finish = 1'b0;
    op_o.ch     = fold_case(text_byte_i);
    unique case (action_i)
      ActByte: op_o.step = 1'b1;
      ActLast: begin
        op_o.step   = 1'b1;
        op_o.finish = 1'b1;
      end
      ActEnd:  op_o.finish = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign push_o = in_valid_i && !qstat_i.full && known;

endmodule

[design/lwm_queue.sv]
module lwm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lwm_pkg::lwm_op_t    op_i,
  input  logic                pop_i,
  output lwm_pkg::lwm_op_t    op_o,
  output lwm_pkg::lwm_qstat_t qstat_o
);
  import lwm_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  lwm_op_t         mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Pointer and fill count updates.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= op_i;
    end
  end

  assign op_o          = mem_q[rd_q];
  assign qstat_o.full  = (cnt_q == CntW'(QueueDepth));
  assign qstat_o.empty = (cnt_q == '0);

endmodule

[design/lwm_back.sv]
module lwm_back #(
  parameter int PatternMax = lwm_pkg::PatternMax,
  localparam int VecW = PatternMax + 1,
  localparam int LenW = $clog2(PatternMax + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            restart_i,
  input  logic [LenW-1:0]                 len_i,
  input  logic [PatternMax-1:0]           in_use_i,
  input  logic [PatternMax-1:0]           pct_i,
  input  logic [PatternMax-1:0]           any_i,
  input  logic [PatternMax-1:0][7:0]      pat_char_i,
  input  logic [PatternMax-1:0][VecW-1:0] span_i,
  input  logic [VecW-1:0]                 start_i,
  input  lwm_pkg::lwm_op_t                op_i,
  input  lwm_pkg::lwm_qstat_t             qstat_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            matched_o
);
  import lwm_pkg::*;

  logic            fresh_q, fresh_d;
  logic [VecW-1:0] vec_q, vec_d;
  logic            out_valid_q, out_valid_d;
  logic            matched_q, matched_d;
  logic            take;
  logic [VecW-1:0] cur;
  logic [VecW-1:0] nv;
  logic [VecW-1:0] cl;
  logic [VecW-1:0] after;

  // Take the next item when the output register is free or being emptied.
  assign take  = !qstat_i.empty && (!out_valid_q || !out_stall_i);
  assign pop_o = take;

  // The vector reads as the start vector right after a restart.
  assign cur = fresh_q ? start_i : vec_q;

  // One step of every active position against the text byte.
  always_comb begin
    nv = '0;
    for (int i = 0; i < PatternMax; i++) begin
      if (cur[i] && pct_i[i]) begin
        nv[i] = 1'b1;
      end else if (cur[i] && in_use_i[i] && (any_i[i] || pat_char_i[i] == op_i.ch)) begin
        nv[i+1] = 1'b1;
      end
    end
  end

  // Close the new vector over runs of percent signs.
  always_comb begin
    for (int k = 0; k < VecW; k++) begin
      cl[k] = nv[k];
      for (int j = 0; j < PatternMax; j++) begin
        if (nv[j] && span_i[j][k]) begin
          cl[k] = 1'b1;
        end
      end
    end
  end

  assign after = op_i.step ? cl : cur;

  // Vector, restart flag and output register updates.
  always_comb begin
    fresh_d     = fresh_q;
    vec_d       = vec_q;
    out_valid_d = out_valid_q;
    matched_d   = matched_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (take) begin
      if (op_i.finish) begin
        fresh_d     = 1'b1;
        out_valid_d = 1'b1;
        matched_d   = after[len_i];
      end else begin
        fresh_d = 1'b0;
        vec_d   = after;
      end
    end
    if (restart_i) begin
      fresh_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q     <= vec_d;
    matched_q <= matched_d;
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

endmodule

[design/like_wildcard_matcher.sv]
// Wildcard string matcher in the style of SQL LIKE.
// Input channel: in_valid_i / in_stall_o carry one item per transfer, an
// action code and a text byte. Action 0 streams a byte, action 1 streams the
// last byte of the text, action 2 ends the text without a byte; code 3 is
// taken and dropped. Each text ends in one result on the output channel
// (out_valid_o / out_stall_i) whose matched_o bit says whether it matched.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 low pattern bytes, 1 high pattern bytes, 2 pattern length) and restarts
// the current text; index 3 is ignored. Write only while the block is idle.
// Throughput is one item per cycle while the receiver does not stall the output
// and the queue is not full. An ending item is written into the front queue,
// then the position update loads the output register, which offers its result.
// When the receiver stalls, the result waits in the output register, items
// pile up in the two-entry queue, and then in_stall_o rises.
// Reset clears the pattern to empty and the queue and output to empty; the
// block can take an item as soon as reset is released.
module like_wildcard_matcher #(
  parameter int PatternMax = lwm_pkg::PatternMax
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        action_i,
  input  logic [7:0]                        text_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              matched_o,
  input  logic                              cfg_we_i,
  input  logic [lwm_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [lwm_pkg::CfgWidth-1:0]      cfg_data_i
);
  import lwm_pkg::*;

  localparam int VecW = PatternMax + 1;
  localparam int LenW = $clog2(PatternMax + 1);

  logic [LenW-1:0]                 len;
  logic [PatternMax-1:0]           in_use;
  logic [PatternMax-1:0]           pct;
  logic [PatternMax-1:0]           any;
  logic [PatternMax-1:0][7:0]      pat_char;
  logic [PatternMax-1:0][VecW-1:0] span;
  logic [VecW-1:0]                 start;
  lwm_qstat_t                      qstat;
  lwm_op_t                         push_op;
  lwm_op_t                         head_op;
  logic                            push;
  logic                            pop;
  logic                            restart;

  // Only a write to an existing register restarts the current text.
  assign restart = cfg_we_i && (cfg_index_i inside {CfgLow, CfgHigh, CfgLen});

  lwm_cfg #(.PatternMax(PatternMax)) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .len_o      (len),
    .in_use_o   (in_use),
    .pct_o      (pct),
    .any_o      (any),
    .pat_char_o (pat_char),
    .span_o     (span),
    .start_o    (start)
  );

  lwm_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .text_byte_i(text_byte_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .op_o       (push_op)
  );

  lwm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (push_op),
    .pop_i  (pop),
    .op_o   (head_op),
    .qstat_o(qstat)
  );

  lwm_back #(.PatternMax(PatternMax)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .len_i      (len),
    .in_use_i   (in_use),
    .pct_i      (pct),
    .any_i      (any),
    .pat_char_i (pat_char),
    .span_i     (span),
    .start_i    (start),
    .op_i       (head_op),
    .qstat_i    (qstat),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .matched_o  (matched_o)
  );

endmodule

[design/lwm_checker.sv]
`include "like_wildcard_matcher_defines.svh"

module lwm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic matched_o
);

  // A stalled result stays offered.
  `LWM_ASSERT_NEXT(a_out_held, out_valid_o && out_stall_i, out_valid_o)

  // A stalled result keeps its value.
  `LWM_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(matched_o))

  // The queue only fills up behind a result that waits to be taken.
  `LWM_ASSERT_IMPLIES(a_stall_needs_result, in_stall_o, out_valid_o)

  // Input stall only rises while a result is held back.
  `LWM_ASSERT_IMPLIES(a_stall_rise, $rose(in_stall_o), $past(out_valid_o && out_stall_i))

endmodule

bind like_wildcard_matcher lwm_checker u_lwm_checker (.*);
